// ===== src/olist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 5;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_SORTED     = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_REMOVE     = 3'd5,
      OP_SEARCH     = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIND_RD,
      S_FIND_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_POP
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  value;
   } result_type;

endpackage

`default_nettype wire

// ===== src/olist_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module olist_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/olist_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module olist_ctrl #(
   parameter int CAPACITY = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_fire,
   input  wire logic [2:0]                 req_op,
   input  wire logic [31:0]                req_val,
   input  wire logic                       out_free,
   output logic                            ready,
   output logic                            done,
   output olist_pkg::result_type           result,
   output logic      [CW-1:0]              count,
   output logic                            mem_we,
   output logic      [AW-1:0]              mem_waddr,
   output logic      [31:0]                mem_wdata,
   output logic                            mem_re,
   output logic      [AW-1:0]              mem_raddr,
   input  wire logic [31:0]                mem_rdata
);
   import olist_pkg::*;

   state_type      state_ff, state_in;
   op_type         op_ff, op_in;
   logic [31:0]    val_ff, val_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [AW-1:0]  head_dec, head_inc;
   logic           full, v_lt_e, e_lt_v;

   // logical position to physical address in the ring
   function automatic logic [AW-1:0] phys(input logic [CW-1:0] i, input logic [AW-1:0] h);
      logic [CW:0] s;
      s = {1'b0, i} + (CW+1)'(h);
      if (s >= (CW+1)'(CAPACITY)) begin
         s = s - (CW+1)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   assign head_dec = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(CAPACITY - 1)) ? '0 : head_ff + AW'(1);
   assign full     = (count_ff == CW'(CAPACITY));
   assign v_lt_e   = $signed(val_ff) < $signed(mem_rdata);
   assign e_lt_v   = $signed(mem_rdata) < $signed(val_ff);
   assign ready    = (state_ff == S_IDLE);
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      op_ff  <= op_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      k_ff   <= k_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      done          = 1'b0;
      result.status = ST_OK;
      result.value  = '0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = val_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_op);
               val_in   = req_val;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff) inside
               OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED: begin
                  if (full) begin
                     if (out_free) begin
                        done          = 1'b1;
                        result.status = ST_FULL;
                        state_in      = S_IDLE;
                     end
                  end else if (op_ff == OP_PUSH_BACK) begin
                     if (out_free) begin
                        mem_we    = 1'b1;
                        mem_waddr = phys(count_ff, head_ff);
                        count_in  = count_ff + CW'(1);
                        done      = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end else if (op_ff == OP_PUSH_FRONT || count_ff == '0) begin
                     if (out_free) begin
                        mem_we    = 1'b1;
                        mem_waddr = head_dec;
                        head_in   = head_dec;
                        count_in  = count_ff + CW'(1);
                        done      = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = head_ff;
                     idx_in    = '0;
                     state_in  = S_FIND_CMP;
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        done          = 1'b1;
                        result.status = ST_MISS;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = (op_ff == OP_POP_FRONT) ? head_ff
                                 : phys(count_ff - CW'(1), head_ff);
                     state_in  = S_POP;
                  end
               end
               OP_REMOVE, OP_SEARCH: begin
                  idx_in   = '0;
                  state_in = S_FIND_RD;
               end
               default: begin
                  if (out_free) begin
                     done     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_FIND_RD: begin
            if (idx_ff == count_ff) begin
               if (op_ff == OP_SORTED) begin
                  k_in     = count_ff;
                  state_in = S_SHIFT_RD;
               end else if (out_free) begin
                  done          = 1'b1;
                  result.status = ST_MISS;
                  state_in      = S_IDLE;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = phys(idx_ff, head_ff);
               state_in  = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (op_ff == OP_SORTED) begin
               if (idx_ff == '0) begin
                  // smaller than the front entry: goes in front
                  if (v_lt_e) begin
                     if (out_free) begin
                        mem_we    = 1'b1;
                        mem_waddr = head_dec;
                        head_in   = head_dec;
                        count_in  = count_ff + CW'(1);
                        done      = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end else begin
                     idx_in   = CW'(1);
                     state_in = S_FIND_RD;
                  end
               end else if (!e_lt_v) begin
                  k_in     = count_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_FIND_RD;
               end
            end else if (mem_rdata == val_ff) begin
               if (op_ff == OP_SEARCH) begin
                  if (out_free) begin
                     done         = 1'b1;
                     result.value = val_ff;
                     state_in     = S_IDLE;
                  end
               end else begin
                  k_in     = idx_ff;
                  state_in = S_SHIFT_RD;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_SHIFT_RD: begin
            if (op_ff == OP_SORTED) begin
               // gap opened at idx: drop the new value in
               if (k_ff == idx_ff) begin
                  if (out_free) begin
                     mem_we    = 1'b1;
                     mem_waddr = phys(idx_ff, head_ff);
                     count_in  = count_ff + CW'(1);
                     done      = 1'b1;
                     state_in  = S_IDLE;
                  end
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = phys(k_ff - CW'(1), head_ff);
                  state_in  = S_SHIFT_WR;
               end
            end else begin
               // gap closed up to the last entry
               if (k_ff + CW'(1) == count_ff) begin
                  if (out_free) begin
                     count_in     = count_ff - CW'(1);
                     done         = 1'b1;
                     result.value = val_ff;
                     state_in     = S_IDLE;
                  end
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = phys(k_ff + CW'(1), head_ff);
                  state_in  = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = phys(k_ff, head_ff);
            mem_wdata = mem_rdata;
            k_in      = (op_ff == OP_SORTED) ? k_ff - CW'(1) : k_ff + CW'(1);
            state_in  = S_SHIFT_RD;
         end
         S_POP: begin
            if (out_free) begin
               if (op_ff == OP_POP_FRONT) begin
                  head_in = head_inc;
               end
               count_in     = count_ff - CW'(1);
               done         = 1'b1;
               result.value = mem_rdata;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/ordered_list_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  tdata                                  tuser
// req_      in         [31:0] item_value                      [2:0] req_type
// rsp_      out        [31:0] out_value, [36:32] entry_count  [1:0] status
//
// entries live in a ring in one synchronous ram (one write, one read port)
// push front/back, pop front/back and unused codes need no scan of the ram
// search/remove scan the ram one entry at a time (read, compare); remove and sorted insert then
// move each entry beyond the hit one place (read, write back)
// reset clears state, head, count and the output valid; ram content needs no clearing
// a finished result waits in the output register; the sequencer stalls on it

module ordered_list_engine_unit #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // item_value
   input  wire logic [2:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // out_value, entry_count, zero pad
   output logic      [1:0]  rsp_tuser    // status
);
   import olist_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic              req_fire, out_free, ctrl_ready, done;
   result_type        result;
   logic [CW-1:0]     count;
   logic [CW+4:0]     count_ext;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [31:0]       mem_wdata, mem_rdata;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff;
   logic [31:0]       value_ff;
   logic [4:0]        ecount_ff;

   assign req_tready = ctrl_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_ext  = {5'b0, count};

   olist_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_op    (req_tuser),
      .req_val   (req_tdata),
      .out_free  (out_free),
      .ready     (ctrl_ready),
      .done      (done),
      .result    (result),
      .count     (count),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   olist_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(32)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // count here is already the post-request value on the done cycle's next edge
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done) begin
         status_ff <= result.status;
         value_ff  <= result.value;
      end
   end

   // entry count follows the ctrl count in the cycle after done
   logic done_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         done_d_ff <= 1'b0;
      end else begin
         done_d_ff <= done;
      end
      if (done_d_ff) begin
         ecount_ff <= count_ext[4:0];
      end
   end

   logic [4:0] ecount_out;
   assign ecount_out = done_d_ff ? count_ext[4:0] : ecount_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, ecount_out, value_ff};
   assign rsp_tuser  = status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second request taken while one is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free)
      else $error("result produced while output register is held");
`endif

endmodule

`default_nettype wire

// ===== dv/ordered_list_checker.sv =====
`timescale 1ns / 1ps

module ordered_list_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               fail_count,
   output int               pending_count,
   output int               response_count
);
   import olist_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
      logic [4:0]  count;
   } list_result_type;

   logic signed [31:0] list_model[$];
   list_result_type    awaited[$];

   function automatic list_result_type apply_request(logic [2:0] op, logic signed [31:0] v);
      list_result_type r;
      int pos;
      int hit;
      r = '0;
      hit = -1;
      if (op inside {OP_REMOVE, OP_SEARCH})
         foreach (list_model[k])
            if (hit < 0 && list_model[k] == v) hit = k;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED: begin
            if (list_model.size() >= CAPACITY_DEF) r.status = ST_FULL;
            else begin
               if (op == OP_PUSH_BACK) pos = list_model.size();
               else if (op == OP_PUSH_FRONT || list_model.size() == 0) pos = 0;
               else if (v < list_model[0]) pos = 0;
               else begin
                  pos = 1;
                  while (pos < list_model.size() && list_model[pos] < v) pos++;
               end
               list_model.insert(pos, v);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (list_model.size() == 0) r.status = ST_MISS;
            else if (op == OP_POP_FRONT) r.value = list_model.pop_front();
            else r.value = list_model.pop_back();
         end
         OP_REMOVE, OP_SEARCH: begin
            if (hit < 0) r.status = ST_MISS;
            else begin
               r.value = list_model[hit];
               if (op == OP_REMOVE) list_model.delete(hit);
            end
         end
         default: ;
      endcase
      r.count = 5'(list_model.size());
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type e;
      if (reset) begin
         list_model.delete();
         awaited.delete();
         fail_count <= 0;
         response_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            awaited.push_back(apply_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            response_count <= response_count + 1;
            if (awaited.size() == 0) begin
               $display("%0t: unexpected response status=%0d value=%0d count=%0d", $time,
                        rsp_tuser, $signed(rsp_tdata[31:0]), rsp_tdata[36:32]);
               fail_count <= fail_count + 1;
            end else begin
               e = awaited.pop_front();
               if (e.status !== rsp_tuser || e.value !== rsp_tdata[31:0]
                   || e.count !== rsp_tdata[36:32] || rsp_tdata[39:37] !== 3'b0) begin
                  $display("%0t: mismatch expected status=%0d value=%0d count=%0d",
                           $time, e.status, $signed(e.value), e.count);
                  $display("%0t:          actual   status=%0d value=%0d count=%0d pad=%0d",
                           $time, rsp_tuser, $signed(rsp_tdata[31:0]), rsp_tdata[36:32],
                           rsp_tdata[39:37]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= awaited.size();
   end
endmodule

// ===== dv/ordered_list_engine_unit_test.sv =====
`timescale 1ns / 1ps

module ordered_list_engine_unit_test;
   import olist_pkg::*;

   // request code with no operation behind it
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count, pending_count, response_count;
   int          sent_count = 0;
   int          stall_left = 0;
   logic        sender_done = 1'b0;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ordered_list_engine_unit dut (.*);

   ordered_list_checker checker_i (.*);

   // value pool: small set so remove/search hit often, plus the extremes and an occasional random value
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         default: return $urandom_range(0, 12) - 6;
      endcase
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 40) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one transfer on the request channel, followed by a random gap when idle_ok is set
   task automatic send_request(logic [2:0] op, logic [31:0] v, bit idle_ok);
      int g;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      g = idle_ok ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // receiver backpressure: mostly short stalls, a few long ones, stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if ((response_count / 200) % 3 == 1) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(10, 40);
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 65);
      end
   end

   initial begin
      logic [2:0] op;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty misses, extremes, full store, duplicates, unused code
      send_request(OP_POP_FRONT, 32'hffff_ffff, 1);
      send_request(OP_POP_BACK, 32'h0, 0);
      send_request(OP_SEARCH, 32'h0, 0);
      send_request(OP_REMOVE, 32'h0, 1);
      send_request(OP_SORTED, 32'h8000_0000, 0);
      send_request(OP_SORTED, 32'h7fff_ffff, 0);
      send_request(OP_SORTED, 32'h0, 1);
      send_request(OP_SORTED, 32'h0, 0);
      send_request(OP_SORTED, 32'h8000_0000, 0);
      send_request(OP_PUSH_FRONT, 32'h7fff_ffff, 0);
      send_request(OP_SORTED, 32'h5, 0);
      send_request(OP_UNUSED, 32'hffff_ffff, 0);
      for (int k = 0; k < 8; k++) send_request(OP_PUSH_BACK, k, 0);
      send_request(OP_PUSH_FRONT, 32'h1, 0);
      send_request(OP_SORTED, 32'h1, 0);
      send_request(OP_SEARCH, 32'h7fff_ffff, 0);
      send_request(OP_REMOVE, 32'h0, 0);
      send_request(OP_SEARCH, 32'h1234, 1);

      // random: phases that lean toward filling or draining the store
      for (int n = 0; n < 1750; n++) begin
         if (n == 600) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         case ((n / 60) % 3)
            0: op = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(0, 2))
                                                 : 3'($urandom_range(3, 7));
            1: op = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(3, 6))
                                                 : 3'($urandom_range(0, 2));
            default: op = 3'($urandom_range(0, 7));
         endcase
         send_request(op, pick_value(), (n / 100) % 4 != 2);
      end
      req_tvalid <= 1'b0;
      sender_done <= 1'b1;
   end

   initial begin
      @(posedge sender_done);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d requests over all request codes, empty and full store,",
               sent_count);
      $display("duplicates, value extremes and random idle on both channels");
      if (fail_count == 0 && pending_count == 0) begin
         $display("ordered_list_engine_unit_test: PASS");
      end else begin
         $display("ordered_list_engine_unit_test: FAIL");
      end
      $finish;
   end

   // hard limit, far beyond the slowest correct run
   initial begin
      #50ms;
      $display("ordered_list_engine_unit_test: FAIL");
      $finish;
   end
endmodule
